>>> design/pbu_pkg.sv
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types and codes for the packed bitmap unpacker: register indexes,
// pixel mode codes and the work entry passed from the front to the back.
// ----------------------------------------------------------------------------
package pbu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PITCH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd3;

    localparam logic [1:0] MODE_1BPP = 2'd0;
    localparam logic [1:0] MODE_2BPP = 2'd1;
    localparam logic [1:0] MODE_4BPP = 2'd2;
    localparam logic [1:0] MODE_8BPP = 2'd3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic [1:0] mode;
        logic [3:0] count;
        logic       row_fin;
        logic       last_row;
    } pbu_entry_t;

endpackage

>>> design/pbu_byte_if.sv
// ----------------------------------------------------------------------------
// pbu_byte_if
// Channel carrying source bitmap bytes with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbu_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);

endinterface

>>> design/pbu_pixel_if.sv
// ----------------------------------------------------------------------------
// pbu_pixel_if
// Channel carrying unpacked 8-bit pixels and their row, image and byte marks.
// ----------------------------------------------------------------------------
interface pbu_pixel_if;

    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       row_end;
    logic       image_end;
    logic       last_of_byte;

    modport source (
        output valid, output pixel_value, output row_end,
        output image_end, output last_of_byte, input ready
    );
    modport sink (
        input valid, input pixel_value, input row_end,
        input image_end, input last_of_byte, output ready
    );

endinterface

>>> design/packed_bitmap_to_8bpp_unpacker_core.sv
// ----------------------------------------------------------------------------
// packed_bitmap_to_8bpp_unpacker_core
// Unpacks a 1, 2, 4 or 8 bit per pixel bitmap, fed one byte per transaction,
// into raw 8-bit pixels, one per transaction, marked with row end, image end
// and last pixel of the byte.
// ----------------------------------------------------------------------------
// The back end emits one pixel per clock while the output is not stalled;
// a source byte yields eight pixels at 1 bpp, four at 2 bpp, two at 4 bpp
// and one at 8 bpp, fewer for the partial last byte of a row. Pitch
// padding bytes and bytes after the image is complete give no pixels and
// are taken by the front end whenever the queue has room; like every other
// byte, they wait while the queue is full. A two-entry queue sits between
// the byte classifier and the pixel emitter, so input is still taken while
// a finished pixel waits in the output register. Configuration must be
// written only while the block is idle; the block itself does not enforce
// it. The image restarts only on reset.
// ----------------------------------------------------------------------------
module packed_bitmap_to_8bpp_unpacker_core
    import pbu_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pbu_byte_if.sink               src,
    pbu_pixel_if.source            pix
);

    logic       push_valid;
    logic       push_ready;
    pbu_entry_t push_entry;
    logic       pop_valid;
    logic       pop_ready;
    pbu_entry_t pop_entry;

    pbu_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .src        (src),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    pbu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    pbu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .pix       (pix)
    );

endmodule

>>> design/pbu_front.sv
// ----------------------------------------------------------------------------
// pbu_front
// Holds the configuration registers, tracks the byte position, the pixels
// left in the row and the rows done, and turns each source byte into a work
// entry telling the back end how many pixels to emit.
// ----------------------------------------------------------------------------
module pbu_front
    import pbu_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pbu_byte_if.sink               src,
    output logic                   push_valid,
    input  logic                   push_ready,
    output pbu_entry_t             push_entry
);

    localparam int BIR_W = $clog2(MAX_WIDTH);
    localparam int PL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);

    logic [1:0]            pixel_mode_reg, pixel_mode_next;
    logic [CFG_DATA_W-1:0] row_width_reg, row_width_next;
    logic [CFG_DATA_W-1:0] source_pitch_reg, source_pitch_next;
    logic [CFG_DATA_W-1:0] row_count_reg, row_count_next;

    logic [BIR_W-1:0] byte_in_row_reg, byte_in_row_next;
    logic [PL_W-1:0]  pixels_left_reg, pixels_left_next;
    logic [ROW_W-1:0] rows_done_reg, rows_done_next;

    logic [31:0]     width_lim;
    logic [31:0]     pitch_sat;
    logic [31:0]     pitch_lim;
    logic [31:0]     rows_lim;
    logic            active;
    logic            row_wrap;
    logic            last_row;
    logic [PL_W-1:0] pl_eff;
    logic [3:0]      per_byte;
    logic [3:0]      n;
    logic            row_fin;
    logic            accept;

    always_comb
    begin
        width_lim = (32'(row_width_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH)
                                                          : 32'(row_width_reg);
        pitch_sat = (32'(source_pitch_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH)
                                                             : 32'(source_pitch_reg);
        pitch_lim = (pitch_sat == 32'd0) ? 32'd1 : pitch_sat;
        rows_lim  = (32'(row_count_reg) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                         : 32'(row_count_reg);
        active    = 32'(rows_done_reg) < rows_lim;
        row_wrap  = (32'(byte_in_row_reg) + 32'd1) >= pitch_lim;
        last_row  = (32'(rows_done_reg) + 32'd1) == rows_lim;
        pl_eff    = (byte_in_row_reg == '0) ? width_lim[PL_W-1:0] : pixels_left_reg;
        per_byte  = 4'd8 >> pixel_mode_reg;
        row_fin   = 32'(pl_eff) <= 32'(per_byte);
        n         = row_fin ? pl_eff[3:0] : per_byte;
    end

    assign src.ready  = push_ready;
    assign accept     = src.valid && push_ready;
    assign push_valid = src.valid && active && (n != 4'd0);

    assign push_entry.source_byte = src.source_byte;
    assign push_entry.mode        = pixel_mode_reg;
    assign push_entry.count       = n;
    assign push_entry.row_fin     = row_fin;
    assign push_entry.last_row    = last_row;

    always_comb
    begin
        pixel_mode_next   = pixel_mode_reg;
        row_width_next    = row_width_reg;
        source_pitch_next = source_pitch_reg;
        row_count_next    = row_count_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PIXEL_MODE:   pixel_mode_next   = cfg_data[1:0];
                REG_ROW_WIDTH:    row_width_next    = cfg_data;
                REG_SOURCE_PITCH: source_pitch_next = cfg_data;
                REG_ROW_COUNT:    row_count_next    = cfg_data;
                default:          pixel_mode_next   = pixel_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        byte_in_row_next = byte_in_row_reg;
        pixels_left_next = pixels_left_reg;
        rows_done_next   = rows_done_reg;
        if (accept && active)
        begin
            if (row_wrap)
            begin
                byte_in_row_next = '0;
                pixels_left_next = '0;
                rows_done_next   = rows_done_reg + 1'b1;
            end
            else
            begin
                byte_in_row_next = byte_in_row_reg + 1'b1;
                pixels_left_next = pl_eff - PL_W'(n);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg   <= MODE_1BPP;
            row_width_reg    <= '0;
            source_pitch_reg <= CFG_DATA_W'(1);
            row_count_reg    <= '0;
            byte_in_row_reg  <= '0;
            pixels_left_reg  <= '0;
            rows_done_reg    <= '0;
        end
        else
        begin
            pixel_mode_reg   <= pixel_mode_next;
            row_width_reg    <= row_width_next;
            source_pitch_reg <= source_pitch_next;
            row_count_reg    <= row_count_next;
            byte_in_row_reg  <= byte_in_row_next;
            pixels_left_reg  <= pixels_left_next;
            rows_done_reg    <= rows_done_next;
        end
    end

endmodule

>>> design/pbu_queue.sv
// ----------------------------------------------------------------------------
// pbu_queue
// Two-entry queue of work entries between the front and the back end.
// The head always sits in the first slot.
// ----------------------------------------------------------------------------
module pbu_queue
    import pbu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  pbu_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output pbu_entry_t pop_entry
);

    pbu_entry_t slot0_reg, slot0_next;
    pbu_entry_t slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_entry  = slot0_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            if (push && count_reg == 2'd1)
            begin
                slot0_next = push_entry;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_next = push_entry;
            end
            else
            begin
                slot1_next = push_entry;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue did not grow on push");

endmodule

>>> design/pbu_back.sv
// ----------------------------------------------------------------------------
// pbu_back
// Takes work entries from the queue; unless the output stalls, emits one pixel
// per cycle from the current byte, MSB field first, via an output register.
// ----------------------------------------------------------------------------
module pbu_back
    import pbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  pbu_entry_t  pop_entry,
    pbu_pixel_if.source pix
);

    pbu_entry_t cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] pixel_value_reg, pixel_value_next;
    logic       row_end_reg, row_end_next;
    logic       image_end_reg, image_end_next;
    logic       last_of_byte_reg, last_of_byte_next;

    logic       out_free;
    logic       fire;
    logic       k_last;
    logic       load;
    logic [5:0] shamt;
    logic [7:0] shifted;
    logic [7:0] pixel;

    assign out_free  = !out_valid_reg || pix.ready;
    assign fire      = out_free && cur_valid_reg;
    assign k_last    = ({1'b0, k_reg} + 4'd1) == cur_reg.count;
    assign pop_ready = !cur_valid_reg || (fire && k_last);
    assign load      = pop_valid && pop_ready;
    assign shamt     = {3'b000, k_reg} << cur_reg.mode;
    assign shifted   = cur_reg.source_byte << shamt;

    always_comb
    begin
        case (cur_reg.mode)
            MODE_1BPP: pixel = {7'd0, shifted[7]};
            MODE_2BPP: pixel = {6'd0, shifted[7:6]};
            MODE_4BPP: pixel = {4'd0, shifted[7:4]};
            MODE_8BPP: pixel = shifted;
            default:   pixel = shifted;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        k_next         = k_reg;
        if (load)
        begin
            cur_next       = pop_entry;
            cur_valid_next = 1'b1;
            k_next         = '0;
        end
        else if (fire && k_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (fire)
        begin
            k_next = k_reg + 1'b1;
        end

        out_valid_next    = out_valid_reg;
        pixel_value_next  = pixel_value_reg;
        row_end_next      = row_end_reg;
        image_end_next    = image_end_reg;
        last_of_byte_next = last_of_byte_reg;
        if (fire)
        begin
            out_valid_next    = 1'b1;
            pixel_value_next  = pixel;
            row_end_next      = k_last && cur_reg.row_fin;
            image_end_next    = k_last && cur_reg.row_fin && cur_reg.last_row;
            last_of_byte_next = k_last;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg          <= cur_next;
        k_reg            <= k_next;
        pixel_value_reg  <= pixel_value_next;
        row_end_reg      <= row_end_next;
        image_end_reg    <= image_end_next;
        last_of_byte_reg <= last_of_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_value  = pixel_value_reg;
    assign pix.row_end      = row_end_reg;
    assign pix.image_end    = image_end_reg;
    assign pix.last_of_byte = last_of_byte_reg;

    a_cur_index: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.count != 4'd0 && {1'b0, k_reg} < cur_reg.count))
        else $error("pixel index outside the current byte");

    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && row_end_reg) |-> last_of_byte_reg)
        else $error("row end not on the last pixel of a byte");

    a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && image_end_reg) |-> row_end_reg)
        else $error("image end without row end");

endmodule

>>> verif/tb_packed_bitmap_to_8bpp_unpacker_core.sv
// ----------------------------------------------------------------------------
// tb_packed_bitmap_to_8bpp_unpacker_core
// Feeds source bytes to the unpacker under 1, 2, 4 and 8 bpp formats and
// several row width, pitch and row count settings. It predicts every pixel
// with a local copy of the row and image position, and checks each pixel
// transaction, field by field, against the oldest prediction. Directed cases
// cover the format extremes and special cases. Random rows follow under
// changing idle patterns after a long output stall; a final image end closes the run.
// ----------------------------------------------------------------------------
module tb_packed_bitmap_to_8bpp_unpacker_core;
    import pbu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH_LIMIT = 4096;
    localparam int ROWS_LIMIT  = 4096;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [7:0] value;
        logic       row_end;
        logic       image_end;
        logic       last_of_byte;
    } pixel_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pbu_byte_if  byte_ch ();
    pbu_pixel_if pixel_ch ();

    packed_bitmap_to_8bpp_unpacker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (byte_ch),
        .pix       (pixel_ch)
    );

    pixel_t expected_pixels[$];

    logic [1:0]  mode_reg;
    logic [12:0] width_reg;
    logic [12:0] pitch_reg;
    logic [12:0] rows_reg;
    int          byte_pos;
    int          pixels_left;
    int          rows_finished;

    int mismatches;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_cycles;

    always #2 clk = ~clk;

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function automatic void unpack_byte(input logic [7:0] b);
        int     rows_lim;
        int     pitch_lim;
        int     bpp;
        int     per_byte;
        int     mask;
        int     n;
        int     bv;
        bit     final_row;
        pixel_t p;
        rows_lim  = (rows_reg > ROWS_LIMIT) ? ROWS_LIMIT : int'(rows_reg);
        pitch_lim = (pitch_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(pitch_reg);
        if (pitch_lim == 0)
            pitch_lim = 1;
        if (rows_finished >= rows_lim)
            return;
        if (byte_pos == 0)
            pixels_left = (width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(width_reg);
        case (mode_reg)
            MODE_1BPP: bpp = 1;
            MODE_2BPP: bpp = 2;
            MODE_4BPP: bpp = 4;
            default:   bpp = 8;
        endcase
        per_byte  = 8 / bpp;
        mask      = (1 << bpp) - 1;
        n         = (pixels_left < per_byte) ? pixels_left : per_byte;
        final_row = (rows_finished + 1 == rows_lim);
        bv        = b;
        for (int k = 0; k < n; k++)
        begin
            p.value        = 8'((bv >> (8 - bpp * (k + 1))) & mask);
            p.row_end      = (pixels_left - k - 1) == 0;
            p.image_end    = p.row_end && final_row;
            p.last_of_byte = (k + 1 == n);
            expected_pixels.push_back(p);
        end
        pixels_left -= n;
        if (byte_pos + 1 >= pitch_lim)
        begin
            byte_pos    = 0;
            pixels_left = 0;
            rows_finished++;
        end
        else
        begin
            byte_pos++;
        end
    endfunction

    always @(posedge clk)
    begin : pixel_ready_gen
        if (stall_cycles > 0)
        begin
            pixel_ch.ready <= 1'b0;
            stall_cycles--;
        end
        else
        begin
            pixel_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        pixel_t got;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            got = '{pixel_ch.pixel_value, pixel_ch.row_end, pixel_ch.image_end,
                    pixel_ch.last_of_byte};
            if (expected_pixels.size() == 0)
            begin
                note_mismatch($sformatf(
                    "unexpected pixel value=%0h row_end=%0b image_end=%0b last_of_byte=%0b",
                    got.value, got.row_end, got.image_end, got.last_of_byte));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.value !== want.value)
                    note_mismatch($sformatf("pixel_value expected %0h actual %0h",
                        want.value, got.value));
                if (got.row_end !== want.row_end)
                    note_mismatch($sformatf("row_end expected %0b actual %0b",
                        want.row_end, got.row_end));
                if (got.image_end !== want.image_end)
                    note_mismatch($sformatf("image_end expected %0b actual %0b",
                        want.image_end, got.image_end));
                if (got.last_of_byte !== want.last_of_byte)
                    note_mismatch($sformatf("last_of_byte expected %0b actual %0b",
                        want.last_of_byte, got.last_of_byte));
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.source_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        unpack_byte(b);
    endtask

    task automatic drain_pixels();
        byte_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            REG_PIXEL_MODE:   mode_reg  = val[1:0];
            REG_ROW_WIDTH:    width_reg = val[12:0];
            REG_SOURCE_PITCH: pitch_reg = val[12:0];
            REG_ROW_COUNT:    rows_reg  = val[12:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_format(input logic [1:0] mode, input int width, input int pitch);
        drain_pixels();
        write_reg(REG_PIXEL_MODE, mode);
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_SOURCE_PITCH, pitch);
    endtask

    // Right after reset the row count is zero, so the image is already complete.
    task automatic test_reset_state();
        push_byte(8'hFF);
        push_byte(8'h00);
        drain_pixels();
        write_reg(REG_ROW_COUNT, 8191);
    endtask

    task automatic test_pixel_modes();
        set_format(MODE_1BPP, 12, 3);
        push_byte(8'h80);
        push_byte(8'h01);
        push_byte(8'hA5);
        set_format(MODE_2BPP, 7, 2);
        push_byte(8'hE4);
        push_byte(8'h1B);
        set_format(MODE_4BPP, 3, 2);
        push_byte(8'hF0);
        push_byte(8'h0F);
        set_format(MODE_8BPP, 2, 3);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h55);
    endtask

    task automatic test_special_cases();
        set_format(MODE_1BPP, 0, 2);
        push_byte(8'hFF);
        push_byte(8'h81);
        set_format(MODE_1BPP, 5, 0);
        push_byte(8'h5A);
        set_format(MODE_1BPP, 8191, 1);
        push_byte(8'hC3);
        set_format(MODE_1BPP, 16, 8191);
        push_byte(8'h3C);
        push_byte(8'h96);
        push_byte(8'h69);
        drain_pixels();
        write_reg(REG_SOURCE_PITCH, 2);
        push_byte(8'h77);
        drain_pixels();
        write_reg(REG_ROW_COUNT, 0);
        push_byte(8'hEE);
        drain_pixels();
        write_reg(REG_ROW_COUNT, 8191);
    endtask

    task automatic test_output_stall();
        set_format(MODE_1BPP, 64, 8);
        stall_cycles = 300;
        for (int i = 0; i < 24; i++)
            push_byte(8'($urandom));
        drain_pixels();
    endtask

    task automatic test_random_rows(input int src_pct, input int snk_pct, input int quota);
        int         sent;
        int         width;
        int         pitch;
        int         needed;
        int         bpp;
        int         rows;
        int         pick;
        logic [1:0] mode;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < quota)
        begin
            mode = 2'($urandom_range(3));
            bpp  = 1 << mode;
            pick = $urandom_range(9);
            if (pick == 0)
                width = 0;
            else if (pick == 1)
                width = ($urandom_range(1) != 0) ? 8191 : WIDTH_LIMIT;
            else
                width = $urandom_range(1, 24);
            needed = (width * bpp + 7) / 8;
            if (width <= 24 && $urandom_range(9) < 8)
                pitch = needed + $urandom_range(0, 2);
            else
                pitch = $urandom_range(0, 3);
            rows = $urandom_range(1, 3);
            set_format(mode, width, pitch);
            for (int i = 0; i < rows * ((pitch == 0) ? 1 : pitch); i++)
            begin
                push_byte(8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_image_end();
        set_format(MODE_1BPP, 10, 3);
        write_reg(REG_ROW_COUNT, rows_finished + 1);
        for (int i = 0; i < 5; i++)
            push_byte(8'($urandom));
        drain_pixels();
    endtask

    initial
    begin : limit_guard
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin : main_sequence
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_write            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        byte_ch.valid        = 1'b0;
        byte_ch.source_byte  = '0;
        pixel_ch.ready       = 1'b0;
        mode_reg             = MODE_1BPP;
        width_reg            = '0;
        pitch_reg            = 13'd1;
        rows_reg             = '0;
        byte_pos             = 0;
        pixels_left          = 0;
        rows_finished        = 0;
        mismatches           = 0;
        stall_cycles         = 0;
        src_idle_pct         = 8;
        snk_idle_pct         = 62;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_pixel_modes();
        test_special_cases();
        test_output_stall();
        test_random_rows(8, 62, 20);
        test_random_rows(62, 8, 20);
        test_random_rows(0, 0, 20);
        test_image_end();

        byte_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
